@@ hdl/ptb_pkg.sv @@
// Shared constants and types of the palindromic tree builder.
package ptb_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int ALPHABET_DEF = 26;
  localparam int CHAR_W       = 5;
  localparam int OUT_W        = 11;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WCHK  = 8'b0000_0010,
    S_WNODE = 8'b0000_0100,
    S_WCHAR = 8'b0000_1000,
    S_EMUL  = 8'b0001_0000,
    S_EREAD = 8'b0010_0000,
    S_EDATA = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } ptb_state_t;

  // Write strobes toward the storage.
  typedef struct packed {
    logic char_we;
    logic node_we;
    logic edge_we;
  } ptb_we_t;

endpackage

@@ hdl/ptb_if.sv @@
// Channel interfaces: symbol input and result output.
interface ptb_in_if import ptb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface ptb_out_if import ptb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] suffix_node;
  logic [OUT_W-1:0] suffix_length;
  logic             added_node;
  logic [OUT_W-1:0] node_count;
  logic             full_res;
  modport source (output valid, output suffix_node, output suffix_length,
                  output added_node, output node_count, output full_res, input ready);
  modport sink   (input valid, input suffix_node, input suffix_length,
                  input added_node, input node_count, input full_res, output ready);
endinterface

@@ hdl/ptb_mem.sv @@
// Storage: character store, node table (length, suffix link) and edge table.
module ptb_mem import ptb_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_DEF
) (
  input  logic                 clk,
  input  ptb_we_t              we,
  input  logic [$clog2(CAPACITY+1)-1:0]               char_waddr,
  input  logic [$clog2(ALPHABET_SIZE+1)-1:0]          char_wdata,
  input  logic [$clog2(CAPACITY+1)-1:0]               char_raddr,
  output logic [$clog2(ALPHABET_SIZE+1)-1:0]          char_rdata,
  input  logic [$clog2(CAPACITY+2)-1:0]               node_waddr,
  input  logic signed [$clog2(CAPACITY+2):0]          node_wlen,
  input  logic [$clog2(CAPACITY+2)-1:0]               node_wlink,
  input  logic [$clog2(CAPACITY+2)-1:0]               node_raddr,
  output logic signed [$clog2(CAPACITY+2):0]          node_rlen,
  output logic [$clog2(CAPACITY+2)-1:0]               node_rlink,
  input  logic [$clog2((CAPACITY+2)*ALPHABET_SIZE)-1:0] edge_waddr,
  input  logic [$clog2(CAPACITY+2)-1:0]               edge_wdata,
  input  logic [$clog2((CAPACITY+2)*ALPHABET_SIZE)-1:0] edge_raddr,
  output logic [$clog2(CAPACITY+2)-1:0]               edge_rdata
);
  localparam int NODE_MAX    = CAPACITY + 2;
  localparam int STORE_DEPTH = CAPACITY + 1;
  localparam int EDEPTH      = NODE_MAX * ALPHABET_SIZE;
  localparam int NW          = $clog2(NODE_MAX);
  localparam int LW          = NW + 1;
  localparam int CW          = $clog2(ALPHABET_SIZE + 1);

  logic [CW-1:0]        char_mem [0:STORE_DEPTH-1];
  logic signed [LW-1:0] len_mem  [0:NODE_MAX-1];
  logic [NW-1:0]        link_mem [0:NODE_MAX-1];
  logic [NW-1:0]        edge_mem [0:EDEPTH-1];

  // character store
  always_ff @(posedge clk) begin
    if (we.char_we) begin
      char_mem[char_waddr] <= char_wdata;
    end
    char_rdata <= char_mem[char_raddr];
  end

  // node table
  always_ff @(posedge clk) begin
    if (we.node_we) begin
      len_mem[node_waddr]  <= node_wlen;
      link_mem[node_waddr] <= node_wlink;
    end
    node_rlen  <= len_mem[node_raddr];
    node_rlink <= link_mem[node_raddr];
  end

  // edge table
  always_ff @(posedge clk) begin
    if (we.edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rdata <= edge_mem[edge_raddr];
  end

endmodule

@@ hdl/ptb_seq.sv @@
// Sequencer: suffix-link walks, node creation, edge-table clear and result register.
module ptb_seq import ptb_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ptb_in_if.sink               in_ch,
  ptb_out_if.source            out_ch,
  output ptb_we_t              we,
  output logic [$clog2(CAPACITY+1)-1:0]               char_waddr,
  output logic [$clog2(ALPHABET_SIZE+1)-1:0]          char_wdata,
  output logic [$clog2(CAPACITY+1)-1:0]               char_raddr,
  input  logic [$clog2(ALPHABET_SIZE+1)-1:0]          char_rdata,
  output logic [$clog2(CAPACITY+2)-1:0]               node_waddr,
  output logic signed [$clog2(CAPACITY+2):0]          node_wlen,
  output logic [$clog2(CAPACITY+2)-1:0]               node_wlink,
  output logic [$clog2(CAPACITY+2)-1:0]               node_raddr,
  input  logic signed [$clog2(CAPACITY+2):0]          node_rlen,
  input  logic [$clog2(CAPACITY+2)-1:0]               node_rlink,
  output logic [$clog2((CAPACITY+2)*ALPHABET_SIZE)-1:0] edge_waddr,
  output logic [$clog2(CAPACITY+2)-1:0]               edge_wdata,
  output logic [$clog2((CAPACITY+2)*ALPHABET_SIZE)-1:0] edge_raddr,
  input  logic [$clog2(CAPACITY+2)-1:0]               edge_rdata
);
  localparam int NODE_MAX    = CAPACITY + 2;
  localparam int STORE_DEPTH = CAPACITY + 1;
  localparam int EDEPTH      = NODE_MAX * ALPHABET_SIZE;
  localparam int NW          = $clog2(NODE_MAX);
  localparam int SW          = $clog2(STORE_DEPTH);
  localparam int LW          = NW + 1;
  localparam int CW          = $clog2(ALPHABET_SIZE + 1);
  localparam int EW          = $clog2(EDEPTH);

  ptb_state_t           state_r, state_nxt;
  logic                 clearing_r, clearing_nxt;
  logic [EW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [NW-1:0]        slen_r, slen_nxt;
  logic [CW-1:0]        sym_r, sym_nxt;
  logic [NW-1:0]        u_r, u_nxt;
  logic [NW-1:0]        wlink_r, wlink_nxt;
  logic                 walk2_r, walk2_nxt;
  logic signed [LW-1:0] plen_r, plen_nxt;
  logic [NW-1:0]        plink_r, plink_nxt;
  logic [EW-1:0]        eaddr_r, eaddr_nxt;
  logic [EW-1:0]        esave_r, esave_nxt;
  logic [NW-1:0]        lsuf_r, lsuf_nxt;
  logic [NW-1:0]        lsuf_len_r, lsuf_len_nxt;
  logic [NW-1:0]        next_r, next_nxt;
  logic                 added_r, added_nxt;
  logic                 full_r, full_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     o_node_r, o_len_r, o_cnt_r;
  logic                 o_added_r, o_full_r;

  logic                 accept;
  logic                 out_free;
  logic signed [LW:0]   idx;
  logic signed [LW-1:0] len_p2;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !clearing_r;

  // mirror position of the current candidate palindrome
  assign idx = $signed({2'b00, slen_r}) - $signed({node_rlen[LW-1], node_rlen})
               - $signed((LW+1)'(2));
  assign len_p2 = plen_r + $signed(LW'(2));

  // read addresses
  assign node_raddr = u_r;
  assign char_raddr = idx[SW-1:0];
  assign edge_raddr = eaddr_r;

  // write ports: clear pass also seeds the sentinel and the empty root
  always_comb begin
    we.char_we = 1'b0;
    we.node_we = 1'b0;
    we.edge_we = 1'b0;
    char_waddr = slen_r[SW-1:0];
    char_wdata = sym_nxt;
    node_waddr = next_r;
    node_wlen  = len_p2;
    node_wlink = edge_rdata;
    edge_waddr = esave_r;
    edge_wdata = next_r;
    if (clearing_r) begin
      we.edge_we = 1'b1;
      edge_waddr = clr_cnt_r;
      edge_wdata = '0;
      if (clr_cnt_r == '0) begin
        we.char_we = 1'b1;
        char_waddr = '0;
        char_wdata = CW'(ALPHABET_SIZE);
        we.node_we = 1'b1;
        node_waddr = '0;
        node_wlen  = '0;
        node_wlink = NW'(1);
      end
    end else if (state_r == S_IDLE && accept && slen_r < NW'(STORE_DEPTH)
                 && int'(in_ch.character) < ALPHABET_SIZE) begin
      we.char_we = 1'b1;
    end else if (state_r == S_EDATA && walk2_r) begin
      we.node_we = 1'b1;
      we.edge_we = 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clearing_nxt  = clearing_r;
    clr_cnt_nxt   = clr_cnt_r;
    slen_nxt      = slen_r;
    sym_nxt       = sym_r;
    u_nxt         = u_r;
    wlink_nxt     = wlink_r;
    walk2_nxt     = walk2_r;
    plen_nxt      = plen_r;
    plink_nxt     = plink_r;
    eaddr_nxt     = eaddr_r;
    esave_nxt     = esave_r;
    lsuf_nxt      = lsuf_r;
    lsuf_len_nxt  = lsuf_len_r;
    next_nxt      = next_r;
    added_nxt     = added_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + EW'(1);
      if (clr_cnt_r == EW'(EDEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          added_nxt = 1'b0;
          full_nxt  = 1'b0;
          sym_nxt   = CW'(in_ch.character);
          if (slen_r >= NW'(STORE_DEPTH)) begin
            full_nxt  = 1'b1;
            state_nxt = S_DONE;
          end else if (int'(in_ch.character) >= ALPHABET_SIZE) begin
            state_nxt = S_DONE;
          end else begin
            slen_nxt  = slen_r + NW'(1);
            u_nxt     = lsuf_r;
            walk2_nxt = 1'b0;
            state_nxt = S_WCHK;
          end
        end
      end
      S_WCHK: begin
        // imaginary root always extends
        if (u_r == NW'(1)) begin
          if (!walk2_r) begin
            plen_nxt  = -$signed(LW'(1));
            plink_nxt = NW'(1);
          end
          state_nxt = S_EMUL;
        end else begin
          state_nxt = S_WNODE;
        end
      end
      S_WNODE: begin
        if (idx < 0) begin
          u_nxt     = node_rlink;
          state_nxt = S_WCHK;
        end else begin
          wlink_nxt = node_rlink;
          if (!walk2_r) begin
            plen_nxt  = node_rlen;
            plink_nxt = node_rlink;
          end
          state_nxt = S_WCHAR;
        end
      end
      S_WCHAR: begin
        if (char_rdata == sym_r) begin
          state_nxt = S_EMUL;
        end else begin
          u_nxt     = wlink_r;
          state_nxt = S_WCHK;
        end
      end
      S_EMUL: begin
        eaddr_nxt = EW'(u_r * ALPHABET_SIZE) + EW'(sym_r);
        state_nxt = S_EREAD;
      end
      S_EREAD: begin
        state_nxt = S_EDATA;
      end
      S_EDATA: begin
        if (walk2_r) begin
          lsuf_nxt     = next_r;
          lsuf_len_nxt = NW'(len_p2);
          next_nxt     = next_r + NW'(1);
          added_nxt    = 1'b1;
          state_nxt    = S_DONE;
        end else if (edge_rdata != '0) begin
          lsuf_nxt     = edge_rdata;
          lsuf_len_nxt = NW'(len_p2);
          state_nxt    = S_DONE;
        end else begin
          esave_nxt = eaddr_r;
          walk2_nxt = 1'b1;
          u_nxt     = plink_r;
          state_nxt = S_WCHK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      slen_r      <= NW'(1);
      lsuf_r      <= '0;
      lsuf_len_r  <= '0;
      next_r      <= NW'(2);
      walk2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      slen_r      <= slen_nxt;
      lsuf_r      <= lsuf_nxt;
      lsuf_len_r  <= lsuf_len_nxt;
      next_r      <= next_nxt;
      walk2_r     <= walk2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    u_r       <= u_nxt;
    wlink_r   <= wlink_nxt;
    plen_r    <= plen_nxt;
    plink_r   <= plink_nxt;
    eaddr_r   <= eaddr_nxt;
    esave_r   <= esave_nxt;
    added_r   <= added_nxt;
    full_r    <= full_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      o_node_r  <= OUT_W'(lsuf_r);
      o_len_r   <= OUT_W'(lsuf_len_r);
      o_cnt_r   <= OUT_W'(next_r);
      o_added_r <= added_r;
      o_full_r  <= full_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.suffix_node   = o_node_r;
  assign out_ch.suffix_length = o_len_r;
  assign out_ch.added_node    = o_added_r;
  assign out_ch.node_count    = o_cnt_r;
  assign out_ch.full_res      = o_full_r;

endmodule

@@ hdl/palindromic_tree_builder.sv @@
// Top level of the palindromic tree (eertree) builder.
//
//  channel  | dir | handshake        | payload
//  in_ch    | in  | valid / ready    | character
//  out_ch   | out | valid / ready    | suffix_node, suffix_length, added_node,
//           |     |                  | node_count, full_res
//
// Each item passes through suffix-link steps (check, node read, symbol compare)
// and an edge lookup, plus another when a node is added; dropped items go
// straight to the result. The suffix-link walks are amortized constant per
// stored symbol. After reset the edge table is cleared entry by entry, with
// input held off. While out_ch stalls one result waits in the result register;
// the next item then waits at the end of the sequencer and input is held off.
module palindromic_tree_builder import ptb_pkg::*; #(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptb_in_if.sink     in_ch,
  ptb_out_if.source  out_ch
);
  localparam int NW = $clog2(CAPACITY + 2);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam int CW = $clog2(ALPHABET_SIZE + 1);
  localparam int EW = $clog2((CAPACITY + 2) * ALPHABET_SIZE);

  ptb_we_t              we;
  logic [SW-1:0]        char_waddr, char_raddr;
  logic [CW-1:0]        char_wdata, char_rdata;
  logic [NW-1:0]        node_waddr, node_wlink, node_raddr, node_rlink;
  logic signed [NW:0]   node_wlen, node_rlen;
  logic [EW-1:0]        edge_waddr, edge_raddr;
  logic [NW-1:0]        edge_wdata, edge_rdata;

  ptb_seq #(.CAPACITY(CAPACITY), .ALPHABET_SIZE(ALPHABET_SIZE)) u_seq (
    .clk, .rst_n, .in_ch, .out_ch, .we,
    .char_waddr, .char_wdata, .char_raddr, .char_rdata,
    .node_waddr, .node_wlen, .node_wlink, .node_raddr, .node_rlen, .node_rlink,
    .edge_waddr, .edge_wdata, .edge_raddr, .edge_rdata
  );

  ptb_mem #(.CAPACITY(CAPACITY), .ALPHABET_SIZE(ALPHABET_SIZE)) u_mem (
    .clk, .we,
    .char_waddr, .char_wdata, .char_raddr, .char_rdata,
    .node_waddr, .node_wlen, .node_wlink, .node_raddr, .node_rlen, .node_rlink,
    .edge_waddr, .edge_wdata, .edge_raddr, .edge_rdata
  );

endmodule

@@ hdl/ptb_chk.sv @@
// Port-level checker for the palindromic tree builder, bound to the top level.
module ptb_chk import ptb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] suffix_node,
  input logic [OUT_W-1:0] suffix_length,
  input logic             added_node,
  input logic [OUT_W-1:0] node_count,
  input logic             full_res
);
  // a stalled result stays valid and keeps its node and count
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(suffix_node) && $stable(node_count))
    else $error("result changed while stalled");

  // a symbol dropped on a full store never adds a node
  a_add_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(added_node && full_res))
    else $error("node added on a full store");

  // a new node is the newest id
  a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && added_node |-> suffix_node == node_count - OUT_W'(1))
    else $error("new node id mismatch");

  // only the empty root has length zero
  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((suffix_node == '0) == (suffix_length == '0)))
    else $error("suffix length inconsistent with node");

endmodule

bind palindromic_tree_builder ptb_chk u_ptb_chk (
  .clk, .rst_n,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .suffix_node(out_ch.suffix_node), .suffix_length(out_ch.suffix_length),
  .added_node(out_ch.added_node), .node_count(out_ch.node_count),
  .full_res(out_ch.full_res)
);

@@ tb/sv/tb_palindromic_tree_builder.sv @@
// Testbench for the palindromic tree builder: directed and random symbol streams checked against a local eertree.
`timescale 1ns / 1ps

// Expected-result store plus its own eertree, built up item by item.
class eertree_scoreboard;
  localparam int CAP   = 1024;
  localparam int ALPH  = 26;
  localparam int NODES = CAP + 2;
  localparam int DEPTH = CAP + 1;

  typedef struct {
    logic [10:0] node;
    logic [10:0] len;
    logic        added;
    logic [10:0] count;
    logic        full;
  } tree_result_t;

  int unsigned  syms[DEPTH];
  int unsigned  str_len;
  int           pal_len[NODES];
  int unsigned  link[NODES];
  int unsigned  child[NODES*ALPH];
  int unsigned  cur_node;
  int unsigned  next_id;
  tree_result_t pending[$];
  int           errors;
  int           checked;
  int           added_total;
  int           full_total;

  function new();
    foreach (syms[i]) syms[i] = 0;
    foreach (pal_len[i]) pal_len[i] = 0;
    foreach (link[i]) link[i] = 0;
    foreach (child[i]) child[i] = 0;
    syms[0] = ALPH;
    str_len = 1;
    pal_len[1] = -1;
    link[0] = 1;
    link[1] = 1;
    cur_node = 0;
    next_id = 2;
    errors = 0;
    checked = 0;
    added_total = 0;
    full_total = 0;
  endfunction

  // Climb suffix links until the palindrome can be wrapped by the last symbol.
  function int unsigned find_extendable(int unsigned start);
    int unsigned u;
    int unsigned last;
    int          pos;
    u = start;
    last = syms[str_len - 1];
    forever begin
      if (u >= NODES) u = 1;
      pos = int'(str_len) - pal_len[u] - 2;
      if (pos >= 0 && pos < int'(str_len) && syms[pos] == last) return u;
      if (u == 1) return 1;
      u = link[u];
    end
  endfunction

  function void note_symbol(logic [4:0] ch);
    tree_result_t r;
    int unsigned  p, q, e, u;
    r.added = 0;
    r.full = 0;
    if (str_len >= DEPTH) begin
      r.full = 1;
    end else if (ch < ALPH) begin
      syms[str_len] = ch;
      str_len++;
      p = find_extendable(cur_node);
      e = p * ALPH + ch;
      if (child[e] == 0 && next_id < NODES) begin
        u = next_id++;
        pal_len[u] = pal_len[p] + 2;
        q = find_extendable(link[p]);
        link[u] = child[q * ALPH + ch];
        child[e] = u;
        r.added = 1;
      end
      cur_node = child[e];
    end
    u = cur_node < NODES ? cur_node : 0;
    r.node = u[10:0];
    r.len = pal_len[u] < 0 ? 11'd0 : pal_len[u][10:0];
    r.count = next_id[10:0];
    pending.push_back(r);
  endfunction

  function void check_result(logic [10:0] node, logic [10:0] len, logic added,
                             logic [10:0] count, logic full);
    tree_result_t x;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result node=%0d len=%0d", $time, node, len);
      errors++;
      return;
    end
    x = pending.pop_front();
    checked++;
    if (added) added_total++;
    if (full) full_total++;
    if (node !== x.node) begin
      $display("%0t: suffix_node exp %0d got %0d", $time, x.node, node); errors++;
    end
    if (len !== x.len) begin
      $display("%0t: suffix_length exp %0d got %0d", $time, x.len, len); errors++;
    end
    if (added !== x.added) begin
      $display("%0t: added_node exp %0d got %0d", $time, x.added, added); errors++;
    end
    if (count !== x.count) begin
      $display("%0t: node_count exp %0d got %0d", $time, x.count, count); errors++;
    end
    if (full !== x.full) begin
      $display("%0t: full_res exp %0d got %0d", $time, x.full, full); errors++;
    end
  endfunction
endclass

module tb_palindromic_tree_builder;
  import ptb_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  bit   hold_out = 0;
  int   sent = 0;

  ptb_in_if  in_ch();
  ptb_out_if out_ch();

  eertree_scoreboard tree = new();

  palindromic_tree_builder dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.character = '0;
    out_ch.ready = 0;
  end

  // Accepted items and results, seen at the clock edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) tree.note_symbol(in_ch.character);
    if (rst_n && out_ch.valid && out_ch.ready)
      tree.check_result(out_ch.suffix_node, out_ch.suffix_length, out_ch.added_node,
                        out_ch.node_count, out_ch.full_res);
  end

  // Receiver stall pattern; long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n || hold_out) out_ch.ready <= 0;
    else if (($time / 2000) % 3 == 0) out_ch.ready <= 1;
    else out_ch.ready <= ($urandom_range(99) < 65);
  end

  // Offer one symbol and hold it until taken.
  task automatic send_symbol(logic [4:0] ch);
    in_ch.valid <= 1;
    in_ch.character <= ch;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic pause_sender(int n);
    in_ch.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // one edge first so the last accepted item is already noted
  task automatic wait_drained();
    in_ch.valid <= 0;
    @(posedge clk);
    while (tree.pending.size() != 0) @(posedge clk);
  endtask

  // Bursts of random symbols over a random alphabet of 2 to 26 symbols, with occasional out-of-range ones.
  task automatic random_burst(int n);
    int alph;
    logic [4:0] ch;
    alph = $urandom_range(25, 1);
    repeat (n) begin
      if ($urandom_range(19) == 0) ch = 5'($urandom_range(31));
      else ch = 5'($urandom_range(alph));
      if (ch == 25 && alph < 25) ch = 5'($urandom_range(alph));
      send_symbol(ch);
    end
    if ($urandom_range(2) == 0) pause_sender($urandom_range(12));
  endtask

  initial begin
    logic [4:0] dir_syms[] = '{0, 0, 0, 25, 0, 0, 1, 2, 1, 26, 31, 30, 1, 2,
                               16, 8, 4, 2, 1, 15, 25, 25, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, repeats, odd/even palindromes, out-of-range symbols
    foreach (dir_syms[i]) send_symbol(dir_syms[i]);
    wait_drained();
    // long receiver hold-off while the sender keeps offering
    hold_out = 1;
    fork
      begin repeat (300) @(posedge clk); hold_out = 0; end
      repeat (40) send_symbol(5'($urandom_range(2)));
    join
    wait_drained();
    // random bursts over growing strings
    while (sent < 850) random_burst($urandom_range(40, 1));
    // send at least 1060 symbols in total to push the store toward its 1024-symbol capacity
    while (sent < 1060) random_burst($urandom_range(30, 1));
    wait_drained();
    repeat (100) @(posedge clk);
    $display("Covered %0d items, %0d results, %0d new nodes, %0d dropped as full.",
             sent, tree.checked, tree.added_total, tree.full_total);
    if (tree.errors == 0 && tree.pending.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/ptb_pkg.sv
hdl/ptb_if.sv
hdl/ptb_mem.sv
hdl/ptb_seq.sv
hdl/palindromic_tree_builder.sv
hdl/ptb_chk.sv
tb/sv/tb_palindromic_tree_builder.sv
